/* src/eds_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and request layouts for the Euclidean distance stream.
// Used by every module of the block; depends on nothing else.
package eds_pkg;

  // Lane count and element format. The request layout below carries four
  // named lanes, so LANES matches that layout.
  localparam int LANES         = 4;
  localparam int ELEMENT_WIDTH = 32;
  localparam int FRAC_BITS     = 16;

  // Port field widths.
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 3;
  localparam int DIST_W  = 32;
  localparam int SUM_W   = 48;

  // Derived sizes.
  localparam int PROD_W     = 2 * ELEMENT_WIDTH;
  localparam int SUM_EXT_W  = SUM_W + $clog2(LANES + 1);
  localparam int PAIRS      = (SUM_W + FRAC_BITS + 1) / 2;
  localparam int ROOT_W     = PAIRS;
  localparam int SCALED_W   = 2 * PAIRS;
  localparam int REM_W      = ROOT_W + 1;
  localparam int CNT_W      = $clog2(PAIRS + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [PROD_W-1:0]  prod_t;

  typedef struct packed {
    field_t              first_lane_0;
    field_t              first_lane_1;
    field_t              first_lane_2;
    field_t              first_lane_3;
    field_t              second_lane_0;
    field_t              second_lane_1;
    field_t              second_lane_2;
    field_t              second_lane_3;
    logic [COUNT_W-1:0]  valid_lanes;
    logic                last_beat;
  } in_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [SUM_W-1:0]  sum_of_squares;
    logic              saturated;
  } out_req_t;

  // Finished sum of one vector pair, handed from the merge stage to the root unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } sum_t;

  function automatic field_t first_elem(input in_req_t req, input int idx);
    field_t v;
    case (idx)
      0:       v = req.first_lane_0;
      1:       v = req.first_lane_1;
      2:       v = req.first_lane_2;
      3:       v = req.first_lane_3;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic field_t second_elem(input in_req_t req, input int idx);
    field_t v;
    case (idx)
      0:       v = req.second_lane_0;
      1:       v = req.second_lane_1;
      2:       v = req.second_lane_2;
      3:       v = req.second_lane_3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/euclidean_distance_stream.sv */
`timescale 1ns / 1ps
// Top level of the streaming Euclidean distance block: lane squares, merge
// accumulator, serial square root. Needs eds_pkg, eds_lane, eds_merge, eds_sqrt.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | eds_pkg::in_req_t (lanes, count, last)
//   out_    | output    | out_valid/out_stall| eds_pkg::out_req_t (root, sum, flag)
//
// Beats are accepted one per cycle while in_stall is low. A beat's squares
// are registered in the lanes on acceptance and are added into the
// accumulator when the lane stage fires. A last beat starts the serial root,
// one root bit per cycle; the result comes with the last root bit and holds until taken.
// While that root runs, non-final beats keep flowing; a further last beat
// waits in the lane stage (and stalls the input) until the root unit is free.
// Reset is synchronous and active low; it clears the accumulator and the
// stage valids, and there is no clearing pass.
module euclidean_distance_stream (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eds_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output eds_pkg::out_req_t out_data
);

  // Lane stage bookkeeping: whether it holds a request and whether that
  // request closes its vector pair.
  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_last_r, s1_last_nxt;
  logic           load;
  logic           fire;
  logic           root_ready;
  eds_pkg::prod_t prod [eds_pkg::LANES];
  eds_pkg::sum_t  total;

  // The lane stage can only be stuck behind a last beat that the root unit
  // cannot take yet.
  assign in_stall = s1_valid_r && s1_last_r && !root_ready;
  assign load     = in_valid && !in_stall;
  assign fire     = s1_valid_r && (!s1_last_r || root_ready);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_last_nxt  = s1_last_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      s1_last_nxt  = in_data.last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_last_r  <= s1_last_nxt;
    end
  end

  // One lane per element pair; lanes at or above the count load zero.
  for (genvar g = 0; g < eds_pkg::LANES; g++) begin : g_lane
    eds_lane u_lane (
      .clk         (clk),
      .en          (load),
      .lane_on     (eds_pkg::COUNT_W'(g) < in_data.valid_lanes),
      .first_elem  (eds_pkg::first_elem(in_data, g)),
      .second_elem (eds_pkg::second_elem(in_data, g)),
      .prod_r      (prod[g])
    );
  end

  eds_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .last  (s1_last_r),
    .prod  (prod),
    .total (total)
  );

  eds_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (fire && s1_last_r),
    .operand   (total),
    .ready     (root_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/eds_lane.sv */
`timescale 1ns / 1ps
// One lane: signed difference of two elements, its magnitude and the
// registered square. Depends on eds_pkg.
module eds_lane (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 lane_on,
  input  eds_pkg::field_t      first_elem,
  input  eds_pkg::field_t      second_elem,
  output eds_pkg::prod_t       prod_r
);

  logic signed [eds_pkg::ELEMENT_WIDTH-1:0] a;
  logic signed [eds_pkg::ELEMENT_WIDTH-1:0] b;
  logic signed [eds_pkg::ELEMENT_WIDTH:0]   diff;
  logic        [eds_pkg::ELEMENT_WIDTH:0]   mag_w;
  logic        [eds_pkg::ELEMENT_WIDTH-1:0] mag;
  eds_pkg::prod_t                           prod_nxt;

  always_comb begin
    a     = $signed(first_elem[eds_pkg::ELEMENT_WIDTH-1:0]);
    b     = $signed(second_elem[eds_pkg::ELEMENT_WIDTH-1:0]);
    diff  = (eds_pkg::ELEMENT_WIDTH+1)'(a) - (eds_pkg::ELEMENT_WIDTH+1)'(b);
    mag_w = diff[eds_pkg::ELEMENT_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
    // The magnitude of the difference never needs the extra sign bit.
    mag   = mag_w[eds_pkg::ELEMENT_WIDTH-1:0];
    prod_nxt = lane_on ? eds_pkg::prod_t'(mag) * eds_pkg::prod_t'(mag) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* src/eds_merge.sv */
`timescale 1ns / 1ps
// Merge stage: rescales the lane squares, adds them to the saturating
// accumulator and hands the total on at the end of a vector. Depends on eds_pkg.
module eds_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic            last,
  input  eds_pkg::prod_t  prod [eds_pkg::LANES],
  output eds_pkg::sum_t   total
);

  logic [eds_pkg::SUM_W-1:0]     acc_r, acc_nxt;
  logic                          sat_r, sat_nxt;
  logic [eds_pkg::SUM_EXT_W-1:0] wide;
  eds_pkg::prod_t                scaled;
  logic [eds_pkg::SUM_W-1:0]     sq;

  always_comb begin
    wide = eds_pkg::SUM_EXT_W'(acc_r);
    for (int i = 0; i < eds_pkg::LANES; i++) begin
      scaled = prod[i] >> eds_pkg::FRAC_BITS;
      sq = (scaled >= eds_pkg::prod_t'(eds_pkg::SUM_MAX)) ? eds_pkg::SUM_MAX
                                                          : scaled[eds_pkg::SUM_W-1:0];
      wide = wide + eds_pkg::SUM_EXT_W'(sq);
    end
    // All terms are non-negative, so reaching the top anywhere in the chain
    // is the same as the full sum reaching it.
    if (wide >= eds_pkg::SUM_EXT_W'(eds_pkg::SUM_MAX)) begin
      total.sum = eds_pkg::SUM_MAX;
      total.sat = 1'b1;
    end else begin
      total.sum = wide[eds_pkg::SUM_W-1:0];
      total.sat = sat_r;
    end

    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (fire) begin
      acc_nxt = last ? '0 : total.sum;
      sat_nxt = last ? 1'b0 : total.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

/* src/eds_sqrt.sv */
`timescale 1ns / 1ps
// Bit-serial floor square root of the scaled sum, one root bit per cycle,
// with the result register of the output channel. Depends on eds_pkg.
module eds_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  eds_pkg::sum_t     operand,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output eds_pkg::out_req_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [eds_pkg::SCALED_W-1:0]  x_r, x_nxt;
  logic [eds_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [eds_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [eds_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  eds_pkg::sum_t                 hold_r, hold_nxt;
  logic [eds_pkg::REM_W+1:0]     shifted;
  logic [eds_pkg::REM_W+1:0]     trial;
  logic [eds_pkg::REM_W+1:0]     diff;

  assign ready     = (state_r == ST_IDLE) || ((state_r == ST_DONE) && !out_stall);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    out_data.distance       = eds_pkg::DIST_W'(root_r);
    out_data.sum_of_squares = hold_r.sum;
    out_data.saturated      = hold_r.sat;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    hold_nxt  = hold_r;

    shifted = {rem_r, x_r[eds_pkg::SCALED_W-1 -: 2]};
    trial   = (eds_pkg::REM_W+2)'({root_r, 2'b01});
    diff    = shifted - trial;

    case (state_r)
      ST_RUN: begin
        x_nxt = x_r << 2;
        if (shifted >= trial) begin
          rem_nxt  = diff[eds_pkg::REM_W-1:0];
          root_nxt = {root_r[eds_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = shifted[eds_pkg::REM_W-1:0];
          root_nxt = {root_r[eds_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == eds_pkg::CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (start && ready) begin
      state_nxt = ST_RUN;
      x_nxt     = eds_pkg::SCALED_W'(operand.sum) << eds_pkg::FRAC_BITS;
      root_nxt  = '0;
      rem_nxt   = '0;
      cnt_nxt   = eds_pkg::CNT_W'(eds_pkg::PAIRS);
      hold_nxt  = operand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r    <= x_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    hold_r <= hold_nxt;
  end

endmodule

/* src/eds_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Euclidean distance stream, bound to its top level.
// Depends on eds_pkg and euclidean_distance_stream.
module eds_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input eds_pkg::out_req_t out_data
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request present right after reset");

  // Each root runs bit by bit, so two results are never back to back.
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result requests delivered in consecutive cycles");

  // A result leaving frees the root unit, so the input cannot be held then.
  a_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while the root unit was being freed");

endmodule

bind euclidean_distance_stream eds_checker u_eds_checker (.*);
